FILE: src/gcis_pkg.sv
// ----------------------------------------------------------------------------
// gcis_pkg
// shared types and constants of the grid cell index search
// ----------------------------------------------------------------------------
package gcis_pkg;

  localparam int MaxCells = 256;  // cells in the chain, node table holds one more

  localparam int CoordW   = 32;  // signed q16.16 coordinate
  localparam int TolW     = 31;  // unsigned q15.16 tolerance
  localparam int SumW     = 33;  // coordinate +/- tolerance, never wraps
  localparam int CfgIdxW  = 8;   // first / last interior cell
  localparam int CountW   = 9;   // cell count, node index, found cell
  localparam int CellIdxW = 10;  // signed result index
  localparam int ModeW    = 3;
  localparam int OutW     = 2;
  localparam int RegSelW  = 2;

  // operations
  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;

  // search modes
  localparam logic [ModeW-1:0] ModePlain   = 3'd0;
  localparam logic [ModeW-1:0] ModeLowOne  = 3'd1;
  localparam logic [ModeW-1:0] ModeHigh    = 3'd2;
  localparam logic [ModeW-1:0] ModeExtLow  = 3'd3;
  localparam logic [ModeW-1:0] ModeExtHigh = 3'd4;

  // outcome codes
  localparam logic [OutW-1:0] OutFound   = 2'd0;
  localparam logic [OutW-1:0] OutClampLo = 2'd1;
  localparam logic [OutW-1:0] OutClampHi = 2'd2;
  localparam logic [OutW-1:0] OutNone    = 2'd3;

  // configuration register indexes
  localparam logic [RegSelW-1:0] RegFirstInterior = 2'd0;
  localparam logic [RegSelW-1:0] RegLastInterior  = 2'd1;
  localparam logic [RegSelW-1:0] RegCellCount     = 2'd2;

  localparam logic signed [CellIdxW-1:0] NoCell = '1;

  // query context, broadcast to every cell while a query is in flight
  typedef struct packed {
    logic signed [SumW-1:0] xpt;       // coordinate plus tolerance
    logic signed [SumW-1:0] xmt;       // coordinate minus tolerance
    logic                   lo_en;
    logic [CountW-1:0]      lo_node;
    logic [CountW-1:0]      hi_node;
    logic                   highest;
    logic                   from_one;
    logic                   extended;
    logic                   bad_mode;
  } qry_t;

  // token handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic              lo_hit;
    logic              hi_hit;
    logic              prev_ok;   // coordinate + tol >= previous node
    logic              found;
    logic [CountW-1:0] idx;
  } trav_t;

endpackage

FILE: src/gcis_if.sv
// ----------------------------------------------------------------------------
// gcis channel interfaces
// valid / ready channels for query beats and result beats
// ----------------------------------------------------------------------------
interface gcis_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [8:0]  node_index;
  logic [31:0] node_value;
  logic [31:0] coordinate;
  logic [30:0] tolerance;
  logic [2:0]  search_mode;

  modport source (
    output valid, op, node_index, node_value, coordinate, tolerance, search_mode,
    input  ready
  );
  modport sink (
    input  valid, op, node_index, node_value, coordinate, tolerance, search_mode,
    output ready
  );
endinterface

interface gcis_out_if;
  logic              valid;
  logic              ready;
  logic signed [9:0] cell_index;
  logic [1:0]        outcome;

  modport source (
    output valid, cell_index, outcome,
    input  ready
  );
  modport sink (
    input  valid, cell_index, outcome,
    output ready
  );
endinterface

FILE: src/grid_cell_index_search.sv
// a query beat registers a start token, which walks all MaxCells+1 node cells,
//   then passes the result stage and the output register; the input stays closed
//   until the result leaves the result stage; node writes give no result
// the output register lets the next beat enter while a result waits
// reset clears control and configuration; node coordinates hold no reset
// ----------------------------------------------------------------------------
// grid_cell_index_search
// one-axis interval search over ascending node coordinates, held in a chain
// of node cells through which each query token walks
// ----------------------------------------------------------------------------
module grid_cell_index_search import gcis_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  gcis_in_if.sink            in_i,
  gcis_out_if.source         out_o,
  input  logic               cfg_we_i,
  input  logic [RegSelW-1:0] cfg_idx_i,
  input  logic [CountW-1:0]  cfg_data_i
);

  // configuration registers
  logic [CfgIdxW-1:0] first_interior_q;
  logic [CfgIdxW-1:0] last_interior_q;
  logic [CountW-1:0]  cell_count_q;

  // control
  logic in_acc, wr_acc, q_acc;
  logic busy_q, start_q;
  logic res_valid_q, res_move;
  logic out_valid_q;

  // query context
  qry_t qry_d, qry_q;
  logic [TolW-1:0] tol;
  logic            ext_mode;

  // cell chain: chain[0] is the start token, chain[k+1] leaves cell k
  trav_t                chain [MaxCells+2];
  logic [MaxCells:0]    cell_vld;
  trav_t                start_tok;

  // result path
  trav_t                          exit_tok;
  logic signed [CellIdxW-1:0]     res_idx_d, res_idx_q, out_idx_q;
  logic [OutW-1:0]                res_out_d, res_out_q, out_code_q;

  assign in_i.ready = !busy_q;
  assign in_acc     = in_i.valid && in_i.ready;
  assign wr_acc     = in_acc && (in_i.op == OpWrite);
  assign q_acc      = in_acc && (in_i.op == OpQuery);

  // configuration write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_interior_q <= CfgIdxW'(1);
      last_interior_q  <= CfgIdxW'(254);
      cell_count_q     <= CountW'(256);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegFirstInterior: first_interior_q <= cfg_data_i[CfgIdxW-1:0];
        RegLastInterior:  last_interior_q  <= cfg_data_i[CfgIdxW-1:0];
        RegCellCount:     cell_count_q     <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // query context from the incoming beat
  assign ext_mode = (in_i.search_mode == ModeExtLow) || (in_i.search_mode == ModeExtHigh);
  assign tol      = (in_i.search_mode == ModePlain) ? '0 : in_i.tolerance;

  always_comb begin
    qry_d.xpt      = SumW'($signed(in_i.coordinate)) + $signed({2'b00, tol});
    qry_d.xmt      = SumW'($signed(in_i.coordinate)) - $signed({2'b00, tol});
    // extended low clamp below node 0 is skipped
    qry_d.lo_en    = !(ext_mode && (first_interior_q == '0));
    qry_d.lo_node  = CountW'(first_interior_q) - CountW'(ext_mode);
    qry_d.hi_node  = CountW'(last_interior_q) + CountW'(1) + CountW'(ext_mode);
    qry_d.highest  = (in_i.search_mode == ModeHigh) || (in_i.search_mode == ModeExtHigh);
    qry_d.from_one = in_i.search_mode == ModeLowOne;
    qry_d.extended = ext_mode;
    qry_d.bad_mode = in_i.search_mode > ModeExtHigh;
  end

  always_ff @(posedge clk_i) begin
    if (q_acc) begin
      qry_q <= qry_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b0;
      busy_q  <= 1'b0;
    end else begin
      start_q <= q_acc;
      if (q_acc) begin
        busy_q <= 1'b1;
      end else if (res_move) begin
        busy_q <= 1'b0;
      end
    end
  end

  // fresh token: no hits yet, no node before cell 0
  always_comb begin
    start_tok         = '0;
    start_tok.valid   = start_q;
  end

  assign chain[0] = start_tok;

  for (genvar k = 0; k <= MaxCells; k++) begin : g_cell
    gcis_cell #(
      .Index (k)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .qry_i        (qry_q),
      .cell_count_i (cell_count_q),
      .wr_en_i      (wr_acc),
      .wr_idx_i     (in_i.node_index),
      .wr_data_i    (in_i.node_value),
      .trav_i       (chain[k]),
      .trav_o       (chain[k+1])
    );
    assign cell_vld[k] = chain[k+1].valid;
  end

  assign exit_tok = chain[MaxCells+1];

  // final decision: bad mode, then low clamp, then high clamp, then the search hit
  always_comb begin
    priority if (qry_q.bad_mode) begin
      res_idx_d = NoCell;
      res_out_d = OutNone;
    end else if (exit_tok.lo_hit) begin
      res_idx_d = CellIdxW'(first_interior_q) - CellIdxW'(qry_q.extended);
      res_out_d = OutClampLo;
    end else if (exit_tok.hi_hit) begin
      res_idx_d = CellIdxW'(last_interior_q) + CellIdxW'(qry_q.extended);
      res_out_d = OutClampHi;
    end else if (exit_tok.found) begin
      res_idx_d = CellIdxW'(exit_tok.idx);
      res_out_d = OutFound;
    end else begin
      res_idx_d = NoCell;
      res_out_d = OutNone;
    end
  end

  assign res_move = res_valid_q && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (exit_tok.valid) begin
        res_valid_q <= 1'b1;
      end else if (res_move) begin
        res_valid_q <= 1'b0;
      end
      if (res_move) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exit_tok.valid) begin
      res_idx_q <= res_idx_d;
      res_out_q <= res_out_d;
    end
    if (res_move) begin
      out_idx_q  <= res_idx_q;
      out_code_q <= res_out_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.cell_index = out_idx_q;
  assign out_o.outcome    = out_code_q;

  // at most one token walks the chain
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cell_vld, start_q}))
    else $error("more than one query token in the cell chain");

  // a token in the chain or a pending result keeps the input closed
  a_busy_cover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_q || (cell_vld != '0) || res_valid_q) |-> busy_q)
    else $error("query in flight while input is open");

  // a token leaving the chain lands in the result stage
  a_exit_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exit_tok.valid |=> res_valid_q)
    else $error("chain exit beat lost");

  // a query beat starts a token in the next cycle
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_acc |=> start_q && busy_q)
    else $error("accepted query did not start a token");

endmodule

FILE: src/gcis_cell.sv
// ----------------------------------------------------------------------------
// gcis_cell
// holds one node coordinate and tests the cell that ends at this node, if any
// ----------------------------------------------------------------------------
module gcis_cell import gcis_pkg::*; #(
  parameter int Index = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qry_t              qry_i,
  input  logic [CountW-1:0] cell_count_i,
  input  logic              wr_en_i,
  input  logic [CountW-1:0] wr_idx_i,
  input  logic [CoordW-1:0] wr_data_i,
  input  trav_t             trav_i,
  output trav_t             trav_o
);

  localparam bit HasCell = Index > 0;
  localparam int CellNo  = (Index > 0) ? Index - 1 : 0;

  logic signed [CoordW-1:0] node_q;
  logic signed [SumW-1:0]   node_ext;
  logic                     gt, lt, at_lo, at_hi, in_range, match;
  trav_t                    trav_d, trav_q;

  assign node_ext = SumW'(node_q);
  assign gt       = qry_i.xmt > node_ext;
  assign lt       = qry_i.xpt < node_ext;
  assign at_lo    = qry_i.lo_en && (int'(qry_i.lo_node) == Index);
  assign at_hi    = int'(qry_i.hi_node) == Index;
  assign in_range = HasCell && (CellNo < int'(cell_count_i)) &&
                    !(qry_i.from_one && (CellNo == 0));
  assign match    = in_range && trav_i.prev_ok && !gt;

  always_comb begin
    trav_d         = trav_i;
    trav_d.lo_hit  = trav_i.lo_hit | (at_lo & lt);
    trav_d.hi_hit  = trav_i.hi_hit | (at_hi & gt);
    trav_d.prev_ok = !lt;
    // highest search keeps the last hit, lowest search the first
    if (match && (qry_i.highest || !trav_i.found)) begin
      trav_d.found = 1'b1;
      trav_d.idx   = CountW'(CellNo);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (int'(wr_idx_i) == Index)) begin
      node_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trav_q <= '0;
    end else begin
      trav_q <= trav_d;
    end
  end

  assign trav_o = trav_q;

endmodule
